@@ rtl/core/tcp_stream_segment_planner_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the segment planner
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef TCP_STREAM_SEGMENT_PLANNER_CORE_MACROS_SVH
`define TCP_STREAM_SEGMENT_PLANNER_CORE_MACROS_SVH

// Checks a property at every rising edge of aclk outside of reset.
`define TSSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by another one.
`define TSSP_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`endif

@@ rtl/core/tssp_pkg.sv @@
// ---------------------------------------------------------------------------
// Segment planner package
// Field widths, mode and register codes, and the control/status bundles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tssp_pkg;

    // Field widths.
    localparam int LEN_W    = 13;
    localparam int PARTS_W  = 6;
    localparam int SEQ_W    = 32;
    localparam int IDENT_W  = 16;
    localparam int MODE_W   = 2;
    localparam int MAXSEG_W = 11;

    // Packed bus widths, rounded up to whole bytes.
    localparam int IN_FIELDS_W  = LEN_W + PARTS_W + SEQ_W + IDENT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LEN_W + LEN_W + SEQ_W + IDENT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MAXSEG_W;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGMENT = 2'd1;

    // Division modes.
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_EQUAL   = 2'd0;
    localparam mode_t MODE_GROW    = 2'd1;
    localparam mode_t MODE_OVERLAP = 2'd2;
    localparam mode_t MODE_INVALID = 2'd3;

    localparam mode_t                MODE_RESET   = MODE_EQUAL;
    localparam logic [MAXSEG_W-1:0]  MAXSEG_RESET = 11'd1460;

    // Segment sizing constants.
    localparam logic [LEN_W-1:0]   FALLBACK_BYTES = 13'd1450;
    localparam logic [LEN_W-1:0]   GROW_STEP      = 13'd50;
    localparam logic [LEN_W-1:0]   OVERLAP_BYTES  = 13'd10;
    localparam logic [PARTS_W-1:0] MAX_REGULAR    = 6'd63;
    localparam int                 FALLBACK_MAX   = ((2 ** LEN_W) - 1) / 1450;

    // Divider step counter width; the divider makes one quotient bit per step.
    localparam int DIV_CNT_W = $clog2(LEN_W);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic emit;
    } tssp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic div_last;
        logic reg_avail;
        logic rem_avail;
        logic out_free;
    } tssp_sts_t;

    // Number of whole fallback pieces in a stream: a handful of constant compares.
    function automatic logic [PARTS_W-1:0] fallback_count(input logic [LEN_W-1:0] len);
        logic [PARTS_W-1:0] n;
        n = '0;
        for (int k = 1; k <= FALLBACK_MAX; k++) begin
            if (32'(len) >= 32'(k) * 32'(FALLBACK_BYTES)) begin
                n = PARTS_W'(k);
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/tssp_ctrl.sv @@
// ---------------------------------------------------------------------------
// Segment planner controller
// Sequences load, equal-share division, setup and descriptor emission.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_stream_segment_planner_core_macros.svh"

module tssp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tssp_pkg::mode_t   mode,
    input  tssp_pkg::tssp_sts_t sts,
    output tssp_pkg::tssp_cmd_t cmd
);
    import tssp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_START  = 5'b00010,
        ST_DIVIDE = 5'b00100,
        ST_SETUP  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (mode == MODE_INVALID || sts.len_zero) begin
                    state_next = ST_IDLE;
                end else if (mode == MODE_EQUAL) begin
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.reg_avail && !sts.rem_avail) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    // The remainder piece closes the run.
                    if (!sts.reg_avail) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `TSSP_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == ST_START, "accepted item did not start")
    `TSSP_ASSERT_NEXT(a_remainder_ends, cmd.emit && !sts.reg_avail, state_reg == ST_IDLE, "run continued after remainder")
    `TSSP_ASSERT(a_emit_needs_room, !cmd.emit || sts.out_free, "descriptor issued into full output")

endmodule

@@ rtl/core/tssp_dp.sv @@
// ---------------------------------------------------------------------------
// Segment planner datapath
// Holds the stream state, a bit-serial divider and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tcp_stream_segment_planner_core_macros.svh"

module tssp_dp #(
    parameter int unsigned MAX_STREAM_BYTES = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  tssp_pkg::mode_t                   mode,
    input  logic [tssp_pkg::MAXSEG_W-1:0]     max_seg,
    input  logic [tssp_pkg::LEN_W-1:0]        in_len,
    input  logic [tssp_pkg::PARTS_W-1:0]      in_parts,
    input  logic [tssp_pkg::SEQ_W-1:0]        in_seq,
    input  logic [tssp_pkg::IDENT_W-1:0]      in_ident,
    input  tssp_pkg::tssp_cmd_t               cmd,
    output tssp_pkg::tssp_sts_t               sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [tssp_pkg::LEN_W-1:0]        out_offset,
    output logic [tssp_pkg::LEN_W-1:0]        out_bytes,
    output logic [tssp_pkg::SEQ_W-1:0]        out_seq,
    output logic [tssp_pkg::IDENT_W-1:0]      out_ident,
    output logic                              out_last
);
    import tssp_pkg::*;

    // Stream state.
    logic [LEN_W-1:0]     len_reg;
    logic [PARTS_W-1:0]   parts_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [IDENT_W-1:0]   ident_reg;
    logic [LEN_W-1:0]     off_reg;
    logic [LEN_W-1:0]     size_reg;
    logic [PARTS_W-1:0]   n_reg;
    logic [PARTS_W-1:0]   cnt_reg;
    logic                 piece_even_reg;

    // Divider state.
    logic [PARTS_W-1:0]   rem_reg;
    logic [LEN_W-1:0]     quot_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [LEN_W-1:0]     out_offset_reg;
    logic [LEN_W-1:0]     out_bytes_reg;
    logic [SEQ_W-1:0]     out_seq_reg;
    logic [IDENT_W-1:0]   out_ident_reg;
    logic                 out_last_reg;

    logic [LEN_W-1:0]     len_sat;
    logic                 is_equal;
    logic                 is_overlap;
    logic [LEN_W:0]       sum_os;
    logic [LEN_W:0]       end_pos;
    logic                 reg_last;
    logic [LEN_W-1:0]     emit_bytes;
    logic                 emit_last;
    logic [LEN_W-1:0]     off_step;
    logic [LEN_W:0]       grow_sum;
    logic                 grow_ok;
    logic [PARTS_W+1:0]   trial;
    logic                 take;
    logic [PARTS_W-1:0]   rem_new;
    logic                 share_zero;
    logic                 share_over;
    logic                 out_free;

    // Lengths above the stream buffer size saturate.
    assign len_sat = (32'(in_len) > MAX_STREAM_BYTES) ? LEN_W'(MAX_STREAM_BYTES) : in_len;

    // Piece selection and stepping.
    always_comb begin
        is_equal   = (mode == MODE_EQUAL);
        is_overlap = (mode == MODE_OVERLAP);
        sum_os     = {1'b0, off_reg} + {1'b0, size_reg};

        sts.len_zero  = (len_reg == '0);
        sts.div_last  = (div_cnt_reg == DIV_CNT_W'(LEN_W - 1));
        sts.rem_avail = (off_reg < len_reg);
        sts.reg_avail = (cnt_reg != MAX_REGULAR)
                        && (is_equal ? (n_reg != '0) : (sum_os < {1'b0, len_reg}));

        // An equal piece is last when it is the final one and ends the stream exactly.
        reg_last   = is_equal && (n_reg == PARTS_W'(1)) && (sum_os == {1'b0, len_reg});
        emit_bytes = sts.reg_avail ? size_reg : (len_reg - off_reg);
        emit_last  = sts.reg_avail ? reg_last : 1'b1;
        end_pos    = {1'b0, off_reg} + {1'b0, emit_bytes};

        // Overlap mode steps back on every second piece.
        off_step = (is_overlap && piece_even_reg) ? (size_reg - OVERLAP_BYTES) : size_reg;
        grow_sum = {1'b0, size_reg} + {1'b0, GROW_STEP};
        grow_ok  = (grow_sum < (LEN_W + 1)'(max_seg));

        out_free     = !out_valid_reg || out_ready;
        sts.out_free = out_free;
    end

    // One restoring division step per cycle.
    always_comb begin
        trial   = {1'b0, rem_reg, quot_reg[LEN_W-1]} - {2'b00, parts_reg};
        take    = !trial[PARTS_W+1];
        rem_new = take ? trial[PARTS_W-1:0] : {rem_reg[PARTS_W-2:0], quot_reg[LEN_W-1]};
    end

    // Share checks after division.
    always_comb begin
        share_zero = (parts_reg == '0) || (quot_reg == '0);
        share_over = (quot_reg > LEN_W'(max_seg));
    end

    // Stream and divider registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            len_reg        <= len_sat;
            parts_reg      <= in_parts;
            seq_reg        <= in_seq;
            ident_reg      <= in_ident;
            off_reg        <= '0;
            size_reg       <= GROW_STEP;
            n_reg          <= '0;
            cnt_reg        <= '0;
            piece_even_reg <= 1'b0;
            rem_reg        <= '0;
            quot_reg       <= len_sat;
            div_cnt_reg    <= '0;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_new;
            quot_reg    <= {quot_reg[LEN_W-2:0], take};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end else if (cmd.setup) begin
            if (share_zero) begin
                n_reg <= '0;
            end else if (share_over) begin
                size_reg <= FALLBACK_BYTES;
                n_reg    <= fallback_count(len_reg);
            end else begin
                size_reg <= quot_reg;
                n_reg    <= parts_reg;
            end
        end else if (cmd.emit && sts.reg_avail) begin
            seq_reg   <= seq_reg + SEQ_W'(size_reg);
            ident_reg <= ident_reg + IDENT_W'(1);
            cnt_reg   <= cnt_reg + PARTS_W'(1);
            if (is_equal) begin
                off_reg <= sum_os[LEN_W-1:0];
                n_reg   <= n_reg - PARTS_W'(1);
            end else begin
                off_reg        <= off_reg + off_step;
                piece_even_reg <= !piece_even_reg;
                if (grow_ok) begin
                    size_reg <= grow_sum[LEN_W-1:0];
                end
            end
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_offset_reg <= off_reg;
            out_bytes_reg  <= emit_bytes;
            out_seq_reg    <= seq_reg;
            out_ident_reg  <= ident_reg;
            out_last_reg   <= emit_last;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_bytes  = out_bytes_reg;
    assign out_seq    = out_seq_reg;
    assign out_ident  = out_ident_reg;
    assign out_last   = out_last_reg;

    `TSSP_ASSERT(a_piece_in_stream, !cmd.emit || (end_pos <= {1'b0, len_reg}), "piece runs past stream end")
    `TSSP_ASSERT(a_last_ends_stream, !(cmd.emit && emit_last) || (end_pos == {1'b0, len_reg}), "last piece does not end stream")
    `TSSP_ASSERT_NEXT(a_emit_fills_output, cmd.emit, out_valid_reg, "issued item not held in output")

endmodule

@@ rtl/core/tcp_stream_segment_planner_core.sv @@
// ---------------------------------------------------------------------------
// TCP stream segment planner
// Cuts one buffered stream into a run of segment descriptors.
// ---------------------------------------------------------------------------
// One input item is taken only while the planner is idle. A start state
// decides the mode; equal mode then runs a bit-serial divider followed by a
// setup state. After that one descriptor goes into the output register
// per cycle while m_tready stays high, at most 64 descriptors per item.
// The next item is accepted as soon as a remainder piece sits in the output
// register; when an equal run ends on an exact piece, the controller checks
// once more in the emit state before it returns to idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_stream_segment_planner_core #(
    parameter int unsigned MAX_STREAM_BYTES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tssp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tssp_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Stream items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // stream_length, part_count, start_seq, start_ident (from bit 0 up)
    input  logic [tssp_pkg::IN_DATA_W-1:0]      s_tdata,
    // Segment descriptor items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // seg_offset, seg_bytes, seg_seq, seg_ident (from bit 0 up)
    output logic [tssp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import tssp_pkg::*;

    mode_t                mode_reg;
    logic [MAXSEG_W-1:0]  max_seg_reg;

    logic [LEN_W-1:0]     in_len;
    logic [PARTS_W-1:0]   in_parts;
    logic [SEQ_W-1:0]     in_seq;
    logic [IDENT_W-1:0]   in_ident;

    logic [LEN_W-1:0]     out_offset;
    logic [LEN_W-1:0]     out_bytes;
    logic [SEQ_W-1:0]     out_seq;
    logic [IDENT_W-1:0]   out_ident;

    tssp_cmd_t            cmd;
    tssp_sts_t            sts;

    // Configuration registers; unknown indexes are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_RESET;
            max_seg_reg <= MAXSEG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIVIDE_MODE: mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_MAX_SEGMENT: max_seg_reg <= cfg_data[MAXSEG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input field unpacking.
    assign in_len   = s_tdata[LEN_W-1:0];
    assign in_parts = s_tdata[LEN_W +: PARTS_W];
    assign in_seq   = s_tdata[LEN_W + PARTS_W +: SEQ_W];
    assign in_ident = s_tdata[LEN_W + PARTS_W + SEQ_W +: IDENT_W];

    tssp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .mode     (mode_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    tssp_dp #(
        .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .max_seg    (max_seg_reg),
        .in_len     (in_len),
        .in_parts   (in_parts),
        .in_seq     (in_seq),
        .in_ident   (in_ident),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_offset (out_offset),
        .out_bytes  (out_bytes),
        .out_seq    (out_seq),
        .out_ident  (out_ident),
        .out_last   (m_tlast)
    );

    // Output field packing, zero filled to whole bytes.
    assign m_tdata = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                      out_ident, out_seq, out_bytes, out_offset};

endmodule

@@ bench/tcp_stream_segment_planner_core_tb.sv @@
// ---------------------------------------------------------------------------
// Segment planner testbench
// Streams are offered in random bursts while the descriptor side stalls on
// its own pattern. A local planner predicts every descriptor run from the
// current mode and size limit, and each descriptor is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_stream_segment_planner_core_tb;

    import tssp_pkg::*;

    localparam int unsigned STREAM_CAP   = 4096;
    localparam int          RUN_CAP      = 64;
    localparam int          SETTLE_TICKS = 48;
    localparam int          TAIL_TICKS   = 100;
    localparam int          CYCLE_LIMIT  = 1000000;

    // One buffered stream as offered to the planner.
    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [PARTS_W-1:0] parts;
        logic [SEQ_W-1:0]   seq;
        logic [IDENT_W-1:0] ident;
    } stream_t;

    // One segment descriptor as produced by the planner.
    typedef struct packed {
        logic [LEN_W-1:0]   offset;
        logic [LEN_W-1:0]   bytes;
        logic [SEQ_W-1:0]   seq;
        logic [IDENT_W-1:0] ident;
        logic               last;
    } segment_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Shadow copy of the planner registers.
    mode_t               plan_mode   = MODE_RESET;
    logic [MAXSEG_W-1:0] plan_maxseg = MAXSEG_RESET;

    segment_t segments_due[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left  = 0;

    tcp_stream_segment_planner_core #(
        .MAX_STREAM_BYTES(STREAM_CAP)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tcp_stream_segment_planner_core_tb: done, errors");
            $finish;
        end
    end

    // Descriptor-side stall pattern: a randomly chosen style holds for a random stretch, then another is drawn.
    always @(posedge aclk) begin : stall_pattern
        int unsigned style;
        int unsigned style_left;
        int unsigned hold_left;
        int unsigned tick;
        tick = tick + 1;
        if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(50, 300);
        end
        style_left = style_left - 1;
        case (style)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (tick % 4) != 0;
            end
            default: begin
                if (hold_left == 0) begin
                    hold_left = $urandom_range(1, 6);
                    m_tready <= ~m_tready;
                end
                hold_left = hold_left - 1;
            end
        endcase
    end

    // Works out the descriptor run of one stream under the current registers.
    function automatic void plan_segments(input stream_t st);
        int unsigned      len;
        int unsigned      parts;
        int unsigned      off;
        int unsigned      size;
        int unsigned      count_left;
        int unsigned      piece;
        logic [SEQ_W-1:0]   sq;
        logic [IDENT_W-1:0] idn;
        segment_t         run[$];
        segment_t         seg;
        len   = st.len;
        parts = st.parts;
        sq    = st.seq;
        idn   = st.ident;
        off   = 0;
        if (len > STREAM_CAP) len = STREAM_CAP;
        if (plan_mode == MODE_INVALID) return;
        if (plan_mode == MODE_EQUAL) begin
            count_left = 0;
            size = (parts != 0) ? len / parts : 0;
            if (size != 0) begin
                count_left = parts;
                // Shares above the limit fall back to fixed-size pieces.
                if (size > plan_maxseg) begin
                    size       = FALLBACK_BYTES;
                    count_left = len / FALLBACK_BYTES;
                end
            end
            while (count_left != 0 && run.size() < RUN_CAP - 1) begin
                seg = '{LEN_W'(off), LEN_W'(size), sq, idn, 1'b0};
                run.push_back(seg);
                sq  = sq + SEQ_W'(size);
                idn = idn + 1'b1;
                off = off + size;
                count_left = count_left - 1;
            end
        end else begin
            piece = 1;
            size  = GROW_STEP;
            while (off + size < len && run.size() < RUN_CAP - 1) begin
                seg = '{LEN_W'(off), LEN_W'(size), sq, idn, 1'b0};
                run.push_back(seg);
                sq  = sq + SEQ_W'(size);
                idn = idn + 1'b1;
                // Every second piece overlaps the next one in overlap mode.
                if (plan_mode == MODE_OVERLAP && piece[0] == 1'b0) begin
                    off = off + size - OVERLAP_BYTES;
                end else begin
                    off = off + size;
                end
                piece = piece + 1;
                if (size + GROW_STEP < plan_maxseg) size = size + GROW_STEP;
            end
        end
        // Remainder piece up to the end of the stream.
        if (off < len) begin
            seg = '{LEN_W'(off), LEN_W'(len - off), sq, idn, 1'b0};
            run.push_back(seg);
        end
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) segments_due.push_back(run[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            error_count = error_count + 1;
        end
    endfunction

    // Checks each accepted descriptor against the oldest prediction.
    always @(posedge aclk) begin : check_segments
        segment_t got;
        segment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.offset = m_tdata[LEN_W-1:0];
            got.bytes  = m_tdata[2*LEN_W-1:LEN_W];
            got.seq    = m_tdata[2*LEN_W+SEQ_W-1:2*LEN_W];
            got.ident  = m_tdata[2*LEN_W+SEQ_W+IDENT_W-1:2*LEN_W+SEQ_W];
            got.last   = m_tlast;
            if (segments_due.size() == 0) begin
                $display("%0t: unexpected descriptor, expected none, actual %0h",
                         $realtime, got);
                error_count = error_count + 1;
            end else begin
                want = segments_due.pop_front();
                check_field("seg_offset", 32'(want.offset), 32'(got.offset));
                check_field("seg_bytes", 32'(want.bytes), 32'(got.bytes));
                check_field("seg_seq", want.seq, got.seq);
                check_field("seg_ident", 32'(want.ident), 32'(got.ident));
                check_field("last_segment", 32'(want.last), 32'(got.last));
            end
        end
    end

    // Offers one stream in the current burst and predicts its run once taken.
    task automatic send_stream(input int unsigned len, input int unsigned parts,
                               input logic [SEQ_W-1:0] seq, input logic [IDENT_W-1:0] ident);
        stream_t     st;
        int unsigned gap;
        st = '{LEN_W'(len), PARTS_W'(parts), seq, ident};
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left = burst_left - 1;
        s_tdata  <= IN_DATA_W'({st.ident, st.seq, st.parts, st.len});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        plan_segments(st);
    endtask

    // Stops offering and waits until the planner has nothing left to do.
    task automatic drain_planner;
        s_tvalid <= 1'b0;
        while (segments_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    // Writes one register while the planner is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_DIVIDE_MODE) plan_mode = mode_t'(value);
        else if (idx == CFG_MAX_SEGMENT) plan_maxseg = value[MAXSEG_W-1:0];
    endtask

    // Equal division with the reset register values.
    task automatic test_reset_defaults;
        send_stream(0, 5, 32'h0000_0000, 16'h0000);
        send_stream(4096, 63, 32'hFFFF_FF00, 16'hFFF0);
        send_stream(8191, 1, 32'h8000_0000, 16'h8000);
        send_stream(5, 10, 32'h1234_5678, 16'h00FF);
        send_stream(100, 0, 32'hFFFF_FFFF, 16'hFFFF);
        send_stream(1460, 1, 32'h0000_0001, 16'h0001);
        send_stream(1461, 1, 32'hFFFF_FA00, 16'h7FFF);
        send_stream(100, 4, 32'hAAAA_AAAA, 16'h5555);
        send_stream(4096, 3, 32'h5555_5555, 16'hAAAA);
        drain_planner();
    endtask

    // Equal division at the smallest limit, where fallback pieces exceed it.
    task automatic test_equal_mode;
        write_register(CFG_DIVIDE_MODE, CFG_DATA_W'(MODE_EQUAL));
        write_register(CFG_MAX_SEGMENT, 11'd200);
        send_stream(4000, 2, 32'hFFFF_F800, 16'hFFFE);
        send_stream(4096, 21, 32'h0F0F_0F0F, 16'h0F0F);
        drain_planner();
    endtask

    // Growing sizes at both extremes of the limit.
    task automatic test_growing_mode;
        write_register(CFG_DIVIDE_MODE, CFG_DATA_W'(MODE_GROW));
        write_register(CFG_MAX_SEGMENT, 11'd1500);
        send_stream(50, 1, 32'h0000_0010, 16'h0010);
        send_stream(51, 1, 32'hFFFF_FFF0, 16'hFFFF);
        send_stream(8191, 9, 32'hDEAD_BEEF, 16'hBEEF);
        drain_planner();
        write_register(CFG_MAX_SEGMENT, 11'd200);
        send_stream(4096, 0, 32'hFFFF_0000, 16'hFFFC);
        drain_planner();
    endtask

    // Growing with overlap on every second piece.
    task automatic test_overlap_mode;
        write_register(CFG_DIVIDE_MODE, CFG_DATA_W'(MODE_OVERLAP));
        send_stream(4096, 63, 32'h7FFF_FFF0, 16'h7FFE);
        send_stream(300, 1, 32'h0000_0000, 16'h0000);
        drain_planner();
        write_register(CFG_MAX_SEGMENT, 11'd1500);
        send_stream(4096, 1, 32'hFFFF_FFFF, 16'hFFFF);
        drain_planner();
    endtask

    // The invalid mode yields no descriptors at all.
    task automatic test_invalid_mode;
        write_register(CFG_DIVIDE_MODE, CFG_DATA_W'(MODE_INVALID));
        send_stream(4096, 63, 32'h1111_1111, 16'h1111);
        send_stream(1, 1, 32'h2222_2222, 16'h2222);
        drain_planner();
    endtask

    // Random streams over a series of register settings.
    task automatic test_random_traffic;
        int          counted;
        int          phase;
        int          in_phase;
        int unsigned len;
        int unsigned parts;
        mode_t       mode;
        logic [MAXSEG_W-1:0] maxseg;
        counted = 0;
        phase   = 0;
        while (counted < 300) begin
            mode = ($urandom_range(0, 9) == 0) ? MODE_INVALID : mode_t'($urandom_range(0, 2));
            if (phase == 0) maxseg = 11'd200;
            else if (phase == 1) maxseg = 11'd1500;
            else maxseg = MAXSEG_W'($urandom_range(200, 1500));
            write_register(CFG_DIVIDE_MODE, CFG_DATA_W'(mode));
            write_register(CFG_MAX_SEGMENT, maxseg);
            for (in_phase = 0; in_phase < ((mode == MODE_INVALID) ? 6 : 25); in_phase++) begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(0, 60);
                    1: len = $urandom_range(4097, 8191);
                    2: len = 4096;
                    default: len = $urandom_range(0, 4096);
                endcase
                case ($urandom_range(0, 7))
                    0: parts = 0;
                    1: parts = 63;
                    2: parts = $urandom_range(1, 4);
                    default: parts = $urandom_range(0, 63);
                endcase
                send_stream(len, parts, $urandom, IDENT_W'($urandom));
                if (mode != MODE_INVALID) counted = counted + 1;
                // Hold off once mid-phase until every descriptor is back.
                if (phase == 3 && in_phase == 12) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (segments_due.size() != 0) @(posedge aclk);
                end
            end
            drain_planner();
            phase = phase + 1;
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_equal_mode();
        test_growing_mode();
        test_overlap_mode();
        test_invalid_mode();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (segments_due.size() != 0) @(posedge aclk);
        repeat (TAIL_TICKS) @(posedge aclk);
        if (error_count == 0) begin
            $display("tcp_stream_segment_planner_core_tb: done, clean");
        end else begin
            $display("tcp_stream_segment_planner_core_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ tcp_stream_segment_planner_core.f @@
+incdir+rtl/core
rtl/core/tssp_pkg.sv
rtl/core/tssp_ctrl.sv
rtl/core/tssp_dp.sv
rtl/core/tcp_stream_segment_planner_core.sv
bench/tcp_stream_segment_planner_core_tb.sv
